[hdl/paced_droptail_tx_queue_assert.svh]
// Assertion macros for the paced drop-tail transmit queue.
`ifndef PACED_DROPTAIL_TX_QUEUE_ASSERT_SVH
`define PACED_DROPTAIL_TX_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PDTQ_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("pdtq check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PDTQ_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("pdtq check failed");

`endif

[hdl/pdtq_pkg.sv]
// Shared types and constants of the paced drop-tail transmit queue.
`timescale 1ns / 1ps
package pdtq_pkg;

  localparam int QUEUE_DEPTH_DEF    = 64;
  localparam int RATE_EXP_LIMIT_DEF = 8;

  localparam int TYPE_W  = 2;
  localparam int ID_W    = 16;
  localparam int DUR_W   = 16;
  localparam int QLEN_W  = 7;
  localparam int BUF_W   = 7;
  localparam int TIMER_W = 24;
  localparam int EXP_W   = 5;
  localparam int ENTRY_W = ID_W + DUR_W;
  // widest left shift of a duration: largest magnitude of the exponent
  localparam int WIDE_W  = DUR_W + (2 ** (EXP_W - 1)) - 1;

  localparam logic [BUF_W-1:0]   BUF_SIZE_RESET = 7'd64;
  localparam logic [TIMER_W-1:0] TIMER_MAX      = 24'hFFFFFF;

  // request type codes on the input channel
  localparam logic [TYPE_W-1:0] REQ_ARRIVE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SLOW   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FAST   = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   packet_id;
    logic [DUR_W-1:0]  duration;
  } req_t;

  typedef struct packed {
    logic              sent_valid;
    logic [ID_W-1:0]   sent_id;
    logic              dropped;
    logic [QLEN_W-1:0] queue_length;
  } res_t;

  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_SLOW,
    OP_FAST,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [ID_W-1:0]  packet_id;
    logic [DUR_W-1:0] duration;
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_FETCH
  } back_state_t;

endpackage

[hdl/pdtq_front.sv]
// Front stage: accepts requests and classifies them into queue operations.
`timescale 1ns / 1ps
module pdtq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pdtq_pkg::req_t req_data,
  output logic           push_valid,
  input  logic           push_ready,
  output pdtq_pkg::op_t  push_op
);
  import pdtq_pkg::*;

  logic     stage_valid;
  op_t      stage_op;
  op_t      op_next;
  logic     accept;

  // decode the request type, clear fields that carry no meaning
  always_comb begin
    op_next.packet_id = '0;
    op_next.duration  = '0;
    unique case (req_data.req_type)
      REQ_ARRIVE: begin
        op_next.kind      = OP_ARRIVE;
        op_next.packet_id = req_data.packet_id;
        op_next.duration  = req_data.duration;
      end
      REQ_SLOW: op_next.kind = OP_SLOW;
      REQ_FAST: op_next.kind = OP_FAST;
      REQ_TICK: op_next.kind = OP_TICK;
      default:  op_next.kind = OP_TICK;
    endcase
  end

  // stall while the stage holds an operation the queue cannot take
  assign req_stall  = stage_valid && !push_ready;
  assign accept     = req_valid && !req_stall;
  assign push_valid = stage_valid;
  assign push_op    = stage_op;

  // hold the classified operation until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op <= op_next;
    end
  end

endmodule

[hdl/pdtq_opq.sv]
// Two-entry operation queue between the front and the back.
`timescale 1ns / 1ps
module pdtq_opq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pdtq_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop,
  output pdtq_pkg::op_t pop_op
);
  import pdtq_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

[hdl/pdtq_back.sv]
// Back end: packet store, server countdown, pacing exponent and result register.
`timescale 1ns / 1ps
module pdtq_back #(
  parameter int QUEUE_DEPTH    = pdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int RATE_EXP_LIMIT = pdtq_pkg::RATE_EXP_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [pdtq_pkg::BUF_W-1:0] cfg_data,
  input  logic                      op_valid,
  output logic                      op_pop,
  input  pdtq_pkg::op_t             op,
  output logic                      res_valid,
  input  logic                      res_stall,
  output pdtq_pkg::res_t            res_data,
  output logic                      fetching
);
  import pdtq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic signed [EXP_W-1:0] EXP_MAX = EXP_W'(RATE_EXP_LIMIT);
  localparam logic signed [EXP_W-1:0] EXP_MIN = -EXP_MAX;

  logic [ENTRY_W-1:0]      mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]      rd_data;

  back_state_t             state, state_next;
  logic [PTR_W-1:0]        head_ptr, head_ptr_next;
  logic [PTR_W-1:0]        tail_ptr, tail_ptr_next;
  logic [FILL_W-1:0]       fill, fill_next;
  logic                    busy, busy_next;
  logic [TIMER_W-1:0]      timer, timer_next;
  logic signed [EXP_W-1:0] rate_exp, rate_exp_next;
  logic [BUF_W-1:0]        buffer_size;
  res_t                    res_next;
  logic                    res_load;
  logic                    out_free;
  logic                    full_drop;
  logic                    wr_en;
  logic [TIMER_W-1:0]      timer_dec;

  // scale a duration by 2^exp, saturate, at least one tick
  function automatic logic [TIMER_W-1:0] scale_dur(input logic [DUR_W-1:0] d,
                                                    input logic signed [EXP_W-1:0] e);
    logic [WIDE_W-1:0]  wide;
    logic [EXP_W-1:0]   mag;
    logic [TIMER_W-1:0] t;
    wide = '0;
    mag  = '0;
    if (e >= 0) begin
      wide = WIDE_W'(d) << e[EXP_W-2:0];
      t = (wide > WIDE_W'(TIMER_MAX)) ? TIMER_MAX : wide[TIMER_W-1:0];
    end else begin
      mag = EXP_W'(-e);
      t   = TIMER_W'(d >> mag);
    end
    if (t == '0) begin
      t = TIMER_W'(1);
    end
    return t;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_free  = !res_valid || !res_stall;
  assign full_drop = (32'(fill) >= 32'(buffer_size)) || (fill == FILL_W'(QUEUE_DEPTH));
  assign timer_dec = (timer != '0) ? timer - TIMER_W'(1) : timer;
  assign fetching  = (state == BK_FETCH);

  // execute one operation per cycle while the result register is free; a send from the store first reads it in BK_FETCH
  always_comb begin
    state_next    = state;
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    fill_next     = fill;
    busy_next     = busy;
    timer_next    = timer;
    rate_exp_next = rate_exp;
    res_next      = res_data;
    res_load      = 1'b0;
    op_pop        = 1'b0;
    wr_en         = 1'b0;
    unique case (state)
      BK_RUN: begin
        if (op_valid && out_free) begin
          op_pop              = 1'b1;
          res_load            = 1'b1;
          res_next.sent_valid = 1'b0;
          res_next.sent_id    = '0;
          res_next.dropped    = 1'b0;
          if (op.kind == OP_TICK) begin
            if (busy) begin
              timer_next = timer_dec;
              if (timer_dec == '0) begin
                if (fill != '0) begin
                  res_load   = 1'b0;
                  state_next = BK_FETCH;
                end else begin
                  busy_next = 1'b0;
                end
              end
            end
          end else if (full_drop) begin
            res_next.dropped = 1'b1;
          end else begin
            unique case (op.kind)
              OP_SLOW: begin
                if (rate_exp < EXP_MAX) begin
                  rate_exp_next = rate_exp + EXP_W'(1);
                end
              end
              OP_FAST: begin
                if (rate_exp > EXP_MIN) begin
                  rate_exp_next = rate_exp - EXP_W'(1);
                end
              end
              OP_ARRIVE: begin
                if (!busy) begin
                  busy_next           = 1'b1;
                  res_next.sent_valid = 1'b1;
                  res_next.sent_id    = op.packet_id;
                  timer_next          = scale_dur(op.duration, rate_exp);
                end else begin
                  wr_en         = 1'b1;
                  tail_ptr_next = ptr_inc(tail_ptr);
                  fill_next     = fill + FILL_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      BK_FETCH: begin
        // send the head packet read last cycle
        res_load            = 1'b1;
        res_next.sent_valid = 1'b1;
        res_next.sent_id    = rd_data[ENTRY_W-1:DUR_W];
        res_next.dropped    = 1'b0;
        head_ptr_next       = ptr_inc(head_ptr);
        fill_next           = fill - FILL_W'(1);
        timer_next          = scale_dur(rd_data[DUR_W-1:0], rate_exp);
        state_next          = BK_RUN;
      end
      default: state_next = BK_RUN;
    endcase
    res_next.queue_length = QLEN_W'(fill_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_RUN;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      fill        <= '0;
      busy        <= 1'b0;
      timer       <= '0;
      rate_exp    <= '0;
      res_valid   <= 1'b0;
      buffer_size <= BUF_SIZE_RESET;
    end else begin
      state     <= state_next;
      head_ptr  <= head_ptr_next;
      tail_ptr  <= tail_ptr_next;
      fill      <= fill_next;
      busy      <= busy_next;
      timer     <= timer_next;
      rate_exp  <= rate_exp_next;
      res_valid <= res_load || (res_valid && res_stall);
      if (cfg_write) begin
        buffer_size <= cfg_data;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= res_next;
    end
  end

  // packet store, registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_ptr] <= {op.packet_id, op.duration};
    end
    rd_data <= mem[head_ptr];
  end

endmodule

[hdl/paced_droptail_tx_queue.sv]
// Top level of the paced drop-tail transmit queue.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (req_type, packet_id, duration)
//   res      out        res_valid/res_stall  res_data (sent_valid, sent_id, dropped,
//                                            queue_length)
//   cfg      in         cfg_valid/cfg_ready  cfg_data (buffer_size)
//
// When nothing stalls, one request per cycle enters and the back end retires one per cycle.
// A tick that sends a stored packet passes through a store-read state in the back end.
// A result passes the front stage register, the op queue and the output register; a stored send also reads the store.
// Synchronous reset; the packet store needs no clearing pass.
// A stalled result holds in the output register while the op queue fills.
`timescale 1ns / 1ps
module paced_droptail_tx_queue #(
  parameter int QUEUE_DEPTH    = pdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int RATE_EXP_LIMIT = pdtq_pkg::RATE_EXP_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  pdtq_pkg::req_t             req_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output pdtq_pkg::res_t             res_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pdtq_pkg::BUF_W-1:0] cfg_data
);
  import pdtq_pkg::*;
  `include "paced_droptail_tx_queue_assert.svh"

  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic q_valid;
  logic q_pop;
  op_t  q_op;
  logic fetching;

  // always take register writes
  assign cfg_ready = 1'b1;

  pdtq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  pdtq_opq u_opq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_op     (q_op)
  );

  pdtq_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .RATE_EXP_LIMIT (RATE_EXP_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .op_valid  (q_valid),
    .op_pop    (q_pop),
    .op        (q_op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .fetching  (fetching)
  );

  `PDTQ_ASSERT_NOW(a_no_id_without_send, res_valid && !res_data.sent_valid, res_data.sent_id == '0)
  `PDTQ_ASSERT_NOW(a_drop_never_sends, res_valid && res_data.dropped, !res_data.sent_valid)
  `PDTQ_ASSERT_NOW(a_no_pop_in_fetch, fetching, !q_pop)
  `PDTQ_ASSERT_NEXT(a_fetch_one_cycle, fetching, !fetching && res_valid && res_data.sent_valid)

endmodule
